FILE: sv/fdl_pkg.sv
// Package for the fractional delay line: field widths, item kinds and the
// control struct passed down the pipeline. No dependencies.
package fdl_pkg;

  localparam int unsigned SampleW = 24;
  localparam int unsigned DelayW  = 26;

  localparam logic KindPush = 1'b0;
  localparam logic KindRead = 1'b1;

  typedef struct packed {
    logic vld;
    logic rd;
  } ctl_t;

endpackage

FILE: sv/fdl_in_if.sv
// Input channel of the delay line: valid/ready plus one push or read word.
// Depends on fdl_pkg for field widths.
interface fdl_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic signed [fdl_pkg::SampleW-1:0] sample_in;
  logic        [fdl_pkg::DelayW-1:0]  delay;

  modport source (output valid, kind, sample_in, delay, input ready);
  modport sink   (input valid, kind, sample_in, delay, output ready);
endinterface

FILE: sv/fdl_out_if.sv
// Output channel of the delay line: valid/ready plus the interpolated sample.
// Depends on fdl_pkg for the sample width.
interface fdl_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [fdl_pkg::SampleW-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface

FILE: sv/fdl_ram.sv
// Generic RAM: one write port, two read ports, registered read with enable.
// No dependencies.
module fdl_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr0_i,
  input  logic [AW-1:0]    raddr1_i,
  output logic [WIDTH-1:0] rdata0_o,
  output logic [WIDTH-1:0] rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_o <= mem_q[raddr0_i];
      rdata1_o <= mem_q[raddr1_i];
    end
  end

endmodule

FILE: sv/fdl_addr.sv
// Address pipeline: write pointer, delay reduction modulo the store length
// and read index / fraction generation (stages 1 to 5). Depends on fdl_pkg.
module fdl_addr #(
  parameter int unsigned DEPTH     = 1024,
  parameter int unsigned FRAC_BITS = 16,
  localparam int unsigned AW       = $clog2(DEPTH)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                acc_i,
  input  logic                                kind_i,
  input  logic signed [fdl_pkg::SampleW-1:0] sample_i,
  input  logic        [fdl_pkg::DelayW-1:0]  delay_i,
  output fdl_pkg::ctl_t                       ctl_o,
  output logic        [AW-1:0]                idx_o,
  output logic        [AW-1:0]                wp_o,
  output logic                                full_o,
  output logic signed [fdl_pkg::SampleW-1:0] wdata_o,
  output logic        [FRAC_BITS-1:0]         frac_o
);

  localparam int unsigned SW = fdl_pkg::SampleW;
  localparam int unsigned IW = fdl_pkg::DelayW - FRAC_BITS;
  localparam int unsigned XW = ((IW > AW) ? IW : AW) + 1;
  localparam int unsigned QW = IW + AW + 1;
  // floor(2^IW / DEPTH): quotient estimate is exact or one low
  localparam logic [IW-1:0] Recip   = IW'((longint'(1) << IW) / DEPTH);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

  logic [AW-1:0] wp_q;
  logic          full_q;

  fdl_pkg::ctl_t ctl1_q, ctl2_q, ctl3_q, ctl4_q, ctl5_q;

  logic signed [SW-1:0] samp1_q, samp2_q, samp3_q, samp4_q, samp5_q;
  logic [IW-1:0]        di1_q, di2_q, di3_q;
  logic [FRAC_BITS-1:0] f1_q, f2_q, f3_q, f4_q, frac5_q;
  logic [AW-1:0]        wp1_q, wp2_q, wp3_q, wp4_q, wp5_q;
  logic                 full1_q, full2_q, full3_q, full4_q, full5_q;
  logic [2*IW-1:0]      prod_d, prod2_q;
  logic [QW-1:0]        qd_d;
  logic [IW-1:0]        qd3_q;
  logic [IW-1:0]        r_d;
  logic [XW-1:0]        rx, rc;
  logic [AW-1:0]        r4_q;
  logic [AW:0]          t, i0x;
  logic [AW-1:0]        idx5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      full_q <= 1'b0;
    end else if (acc_i && kind_i == fdl_pkg::KindPush) begin
      if (wp_q == LastIdx) begin
        wp_q   <= '0;
        full_q <= 1'b1;
      end else begin
        wp_q <= wp_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
      ctl4_q <= '0;
      ctl5_q <= '0;
    end else if (en_i) begin
      ctl1_q <= '{vld: acc_i, rd: (kind_i == fdl_pkg::KindRead)};
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
      ctl4_q <= ctl3_q;
      ctl5_q <= ctl4_q;
    end
  end

  assign prod_d = (2*IW)'(di1_q) * (2*IW)'(Recip);
  assign qd_d   = QW'(prod2_q[2*IW-1:IW]) * QW'(DEPTH);
  assign r_d    = di3_q - qd3_q;
  assign rx     = XW'(r_d);
  assign rc     = (rx >= XW'(DEPTH)) ? rx - XW'(DEPTH) : rx;
  // position = wp - delay; a nonzero fraction borrows one from the index
  assign t      = {1'b0, wp4_q} - {1'b0, r4_q} - (AW+1)'(|f4_q);
  assign i0x    = t[AW] ? t + (AW+1)'(DEPTH) : t;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      samp1_q <= sample_i;
      di1_q   <= delay_i[fdl_pkg::DelayW-1:FRAC_BITS];
      f1_q    <= delay_i[FRAC_BITS-1:0];
      wp1_q   <= wp_q;
      full1_q <= full_q;

      samp2_q <= samp1_q;
      di2_q   <= di1_q;
      f2_q    <= f1_q;
      wp2_q   <= wp1_q;
      full2_q <= full1_q;
      prod2_q <= prod_d;

      samp3_q <= samp2_q;
      di3_q   <= di2_q;
      f3_q    <= f2_q;
      wp3_q   <= wp2_q;
      full3_q <= full2_q;
      qd3_q   <= qd_d[IW-1:0];

      samp4_q <= samp3_q;
      f4_q    <= f3_q;
      wp4_q   <= wp3_q;
      full4_q <= full3_q;
      r4_q    <= rc[AW-1:0];

      samp5_q <= samp4_q;
      wp5_q   <= wp4_q;
      full5_q <= full4_q;
      idx5_q  <= ctl4_q.rd ? i0x[AW-1:0] : wp4_q;
      frac5_q <= ~f4_q + FRAC_BITS'(1);
    end
  end

  assign ctl_o   = ctl5_q;
  assign idx_o   = idx5_q;
  assign wp_o    = wp5_q;
  assign full_o  = full5_q;
  assign wdata_o = samp5_q;
  assign frac_o  = frac5_q;

endmodule

FILE: sv/fdl_interp.sv
// Interpolation pipeline: masks unwritten entries to zero, then
// s0 + floor((s1 - s0) * frac / 2^FRAC_BITS) (stages 6 to 8). Depends on fdl_pkg.
module fdl_interp #(
  parameter int unsigned AW        = 10,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  fdl_pkg::ctl_t                       ctl_i,
  input  logic        [AW-1:0]                idx_i,
  input  logic        [AW-1:0]                nidx_i,
  input  logic        [AW-1:0]                wp_i,
  input  logic                                full_i,
  input  logic        [FRAC_BITS-1:0]         frac_i,
  input  logic signed [fdl_pkg::SampleW-1:0] rdata0_i,
  input  logic signed [fdl_pkg::SampleW-1:0] rdata1_i,
  output logic                                vld_o,
  output logic signed [fdl_pkg::SampleW-1:0] res_o
);

  localparam int unsigned SW = fdl_pkg::SampleW;
  localparam int unsigned PW = SW + FRAC_BITS + 2;

  logic                 rv6_q, rv7_q, rv8_q;
  logic                 ok0_q, ok1_q;
  logic [FRAC_BITS-1:0] frac6_q, frac7_q;
  logic signed [SW-1:0] s0, s1;
  logic signed [SW:0]   diff_d, diff7_q;
  logic signed [SW-1:0] s0_7_q, s0_8_q;
  logic signed [PW-1:0] prod_d, prod8_q, shifted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv6_q <= 1'b0;
      rv7_q <= 1'b0;
      rv8_q <= 1'b0;
    end else if (en_i) begin
      rv6_q <= ctl_i.vld && ctl_i.rd;
      rv7_q <= rv6_q;
      rv8_q <= rv7_q;
    end
  end

  // entries are written in index order from reset, so anything at or past
  // the write pointer before the first wrap has never been written
  assign s0     = ok0_q ? rdata0_i : '0;
  assign s1     = ok1_q ? rdata1_i : '0;
  assign diff_d = (SW+1)'(s1) - (SW+1)'(s0);
  assign prod_d = PW'(diff7_q) * PW'($signed({1'b0, frac7_q}));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok0_q   <= full_i || (idx_i < wp_i);
      ok1_q   <= full_i || (nidx_i < wp_i);
      frac6_q <= frac_i;

      diff7_q <= diff_d;
      s0_7_q  <= s0;
      frac7_q <= frac6_q;

      prod8_q <= prod_d;
      s0_8_q  <= s0_7_q;
    end
  end

  assign shifted = prod8_q >>> FRAC_BITS;
  assign vld_o   = rv8_q;
  assign res_o   = s0_8_q + shifted[SW-1:0];

endmodule

FILE: sv/fdl_obuf.sv
// Output register with a one-word skid stage; its full flag stalls the
// pipeline. Depends on fdl_pkg and fdl_out_if.
module fdl_obuf (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                res_vld_i,
  input  logic signed [fdl_pkg::SampleW-1:0] res_i,
  output logic                                stall_o,
  fdl_out_if.source                           out_o
);

  logic                                ov_q, sv_q, take;
  logic signed [fdl_pkg::SampleW-1:0] od_q, sd_q;

  assign take = !ov_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (take) begin
      ov_q <= sv_q || res_vld_i;
      sv_q <= 1'b0;
    end else if (res_vld_i && !sv_q) begin
      sv_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      od_q <= sv_q ? sd_q : res_i;
    end else if (res_vld_i && !sv_q) begin
      sd_q <= res_i;
    end
  end

  assign stall_o          = sv_q;
  assign out_o.valid      = ov_q;
  assign out_o.sample_out = od_q;

endmodule

FILE: sv/fractional_delay_line_lerp.sv
// Fractional delay line with linear interpolation, top level.
// Throughput: one word per cycle; in_i.ready drops only while the skid word waits.
// An accepted read passes the address stages for the delay reduction, then the RAM
// read, registered with the first of 3 interpolation stages, and reaches the output register.
// Reset clears the write pointer and pipeline; the store is not swept, entries not
// yet written read as zero by comparing the index with the write pointer.
module fractional_delay_line_lerp #(
  parameter int unsigned DEPTH     = 1024,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fdl_in_if.sink    in_i,
  fdl_out_if.source out_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned SW = fdl_pkg::SampleW;

  logic                 en, stall, acc, ram_we;
  fdl_pkg::ctl_t        s5_ctl;
  logic [AW-1:0]        s5_idx, s5_nidx, s5_wp;
  logic                 s5_full;
  logic signed [SW-1:0] s5_wdata;
  logic [FRAC_BITS-1:0] s5_frac;
  logic [SW-1:0]        rdata0, rdata1;
  logic                 res_vld;
  logic signed [SW-1:0] res;

  assign en         = !stall;
  assign in_i.ready = en;
  assign acc        = in_i.valid && en;

  fdl_addr #(
    .DEPTH    (DEPTH),
    .FRAC_BITS(FRAC_BITS)
  ) u_addr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .acc_i   (acc),
    .kind_i  (in_i.kind),
    .sample_i(in_i.sample_in),
    .delay_i (in_i.delay),
    .ctl_o   (s5_ctl),
    .idx_o   (s5_idx),
    .wp_o    (s5_wp),
    .full_o  (s5_full),
    .wdata_o (s5_wdata),
    .frac_o  (s5_frac)
  );

  assign s5_nidx = (s5_idx == AW'(DEPTH - 1)) ? '0 : s5_idx + AW'(1);
  assign ram_we  = en && s5_ctl.vld && !s5_ctl.rd;

  fdl_ram #(
    .WIDTH(SW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s5_idx),
    .wdata_i (s5_wdata),
    .re_i    (en),
    .raddr0_i(s5_idx),
    .raddr1_i(s5_nidx),
    .rdata0_o(rdata0),
    .rdata1_o(rdata1)
  );

  fdl_interp #(
    .AW       (AW),
    .FRAC_BITS(FRAC_BITS)
  ) u_interp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .ctl_i   (s5_ctl),
    .idx_i   (s5_idx),
    .nidx_i  (s5_nidx),
    .wp_i    (s5_wp),
    .full_i  (s5_full),
    .frac_i  (s5_frac),
    .rdata0_i(rdata0),
    .rdata1_i(rdata1),
    .vld_o   (res_vld),
    .res_o   (res)
  );

  fdl_obuf u_obuf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .res_vld_i(res_vld),
    .res_i    (res),
    .stall_o  (stall),
    .out_o    (out_o)
  );

`ifndef SYNTHESIS
  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |-> out_o.valid)
    else $error("skid word held while output register empty");

  a_skid_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(stall) |-> $past(out_o.valid && out_o.ready))
    else $error("skid word released without output handshake");

  a_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s5_ctl.vld |-> ({1'b0, s5_idx} < (AW+1)'(DEPTH)) && ({1'b0, s5_nidx} < (AW+1)'(DEPTH)))
    else $error("store index out of range");
`endif

endmodule

FILE: sim/fdl_lerp_checker.sv
// Scoreboard for the fractional delay line: mirrors the sample store and write
// pointer, predicts each interpolated read and compares it with the output word.
// Depends on fdl_pkg, fdl_in_if and fdl_out_if.
module fdl_lerp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  fdl_in_if           in_mon,
  fdl_out_if          out_mon,
  output int unsigned err_cnt_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SampleW  = fdl_pkg::SampleW;
  localparam int unsigned DelayW   = fdl_pkg::DelayW;
  localparam int unsigned Depth    = 1024;
  localparam int unsigned FracBits = 16;
  localparam int unsigned IdxW     = $clog2(Depth);

  logic signed [SampleW-1:0] line_mem [Depth];
  logic        [IdxW-1:0]    wr_idx;
  logic signed [SampleW-1:0] sample_due [$];
  logic signed [SampleW-1:0] want;
  int unsigned               mism;

  // Read position is wr_idx - delay in Q10.16; the 26-bit wrap does the modulo.
  function automatic logic signed [SampleW-1:0] interp_sample(logic [DelayW-1:0] dly);
    logic [DelayW-1:0] pos;
    logic [IdxW-1:0]   i0;
    logic [IdxW-1:0]   i1;
    longint            s0;
    longint            s1;
    longint            frac;
    longint            prod;
    pos  = {wr_idx, {FracBits{1'b0}}} - dly;
    i0   = pos[DelayW-1 -: IdxW];
    i1   = i0 + 1'b1;
    frac = longint'(pos[FracBits-1:0]);
    s0   = longint'(line_mem[i0]);
    s1   = longint'(line_mem[i1]);
    prod = (s1 - s0) * frac;
    // arithmetic shift of a signed value floors toward minus infinity
    return SampleW'(s0 + (prod >>> FracBits));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) line_mem[i] = '0;
      wr_idx = '0;
      sample_due.delete();
      mism = 0;
    end else begin
      // output first: a read accepted on this edge cannot complete on it
      if (out_mon.valid && out_mon.ready) begin
        if (sample_due.size() == 0) begin
          $error("sample_out: expected no word, actual %0d", out_mon.sample_out);
          mism++;
        end else begin
          want = sample_due.pop_front();
          if (out_mon.sample_out !== want) begin
            $error("sample_out: expected %0d, actual %0d", want, out_mon.sample_out);
            mism++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.kind == fdl_pkg::KindRead) begin
          sample_due.push_back(interp_sample(in_mon.delay));
        end else begin
          line_mem[wr_idx] = in_mon.sample_in;
          wr_idx = wr_idx + 1'b1;
        end
      end
    end
    err_cnt_o <= mism;
    pending_o <= sample_due.size();
  end

endmodule

FILE: sim/fractional_delay_line_lerp_test.sv
// Testbench top for fractional_delay_line_lerp: drives push/read words with random
// gaps and output stalls, gives the verdict. Prediction lives in fdl_lerp_checker.
// Depends on fdl_pkg, fdl_in_if, fdl_out_if and the RTL top.
module fractional_delay_line_lerp_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SampleW    = fdl_pkg::SampleW;
  localparam int unsigned DelayW     = fdl_pkg::DelayW;
  localparam int unsigned FracW      = 16;
  localparam int unsigned IdxW       = 10;
  localparam int unsigned StuckLimit = 1000;
  localparam int unsigned LongHold   = 64;

  localparam logic signed [SampleW-1:0] SampleMax = {1'b0, {(SampleW-1){1'b1}}};
  localparam logic signed [SampleW-1:0] SampleMin = {1'b1, {(SampleW-1){1'b0}}};

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        quiet  = 1'b0;
  int unsigned err_cnt;
  int unsigned pending;
  int unsigned stuck  = 0;

  fdl_in_if  in_ch ();
  fdl_out_if out_ch ();

  fractional_delay_line_lerp DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  fdl_lerp_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .err_cnt_o (err_cnt),
    .pending_o (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic logic signed [SampleW-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return SampleMax;
      1:       return SampleMin;
      2:       return '0;
      3:       return '1;
      default: return SampleW'($urandom);
    endcase
  endfunction

  // mostly short delays inside the written region, some near the full length
  function automatic logic [DelayW-1:0] pick_delay();
    logic [FracW-1:0] f;
    f = FracW'($urandom);
    case ($urandom_range(0, 7))
      0, 1:    return DelayW'($urandom);
      2:       return {IdxW'($urandom_range(0, 8)), {FracW{1'b0}}};
      3:       return {IdxW'($urandom_range(1016, 1023)), f};
      default: return {IdxW'($urandom_range(0, 12)), f};
    endcase
  endfunction

  // Holds the word until taken; returns on the accepting edge, after an optional gap.
  task automatic send_word(logic knd, logic signed [SampleW-1:0] smp,
                           logic [DelayW-1:0] dly);
    in_ch.kind      <= knd;
    in_ch.sample_in <= smp;
    in_ch.delay     <= dly;
    in_ch.valid     <= 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic send_random(int unsigned push_pct);
    if ($urandom_range(0, 99) < push_pct) begin
      send_word(fdl_pkg::KindPush, pick_sample(), pick_delay());
    end else begin
      send_word(fdl_pkg::KindRead, pick_sample(), pick_delay());
    end
  endtask

  // output ready: short random stalls, plus two long hold-offs to back up the pipe
  initial begin
    int unsigned cyc;
    int unsigned hold;
    cyc  = 0;
    hold = 0;
    out_ch.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc == 120 || cyc == 280) hold = LongHold;
      if (hold != 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        hold = $urandom_range(0, 3);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
    end
    if (stuck >= StuckLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.kind      <= fdl_pkg::KindPush;
    in_ch.sample_in <= '0;
    in_ch.delay     <= '0;
    wait (rst_ni);
    @(posedge clk_i);

    // empty store, shortest and longest delay
    send_word(fdl_pkg::KindRead, pick_sample(), '0);
    send_word(fdl_pkg::KindRead, pick_sample(), '1);
    // entries 0..3: min, max, -1, 1
    send_word(fdl_pkg::KindPush, SampleMin, pick_delay());
    send_word(fdl_pkg::KindPush, SampleMax, pick_delay());
    send_word(fdl_pkg::KindPush, '1, pick_delay());
    send_word(fdl_pkg::KindPush, SampleW'(1), pick_delay());
    send_word(fdl_pkg::KindRead, pick_sample(), 26'h0030001); // min -> max, top fraction
    send_word(fdl_pkg::KindRead, pick_sample(), 26'h0020001); // max -> -1, slope floors
    send_word(fdl_pkg::KindRead, pick_sample(), 26'h0018000); // -1 -> 1 at one half
    send_word(fdl_pkg::KindRead, pick_sample(), 26'h0010000); // whole delay, no fraction
    send_word(fdl_pkg::KindRead, pick_sample(), 26'h0000000); // unwritten entry at pointer
    send_word(fdl_pkg::KindRead, pick_sample(), 26'h004C000); // last entry, wraps to 0
    send_word(fdl_pkg::KindRead, pick_sample(), '1);          // longest delay wraps around
    send_word(fdl_pkg::KindRead, pick_sample(), 26'h0040000);
    send_word(fdl_pkg::KindRead, pick_sample(), 26'h3FF0000);
    send_word(fdl_pkg::KindRead, pick_sample(), 26'h0038000); // min -> max at one half

    repeat (120) send_random(60);

    // push-heavy stretch: reads land mostly on freshly written entries
    repeat (160) send_random(88);

    quiet <= 1'b1;
    repeat (100) send_random(50);
    in_ch.valid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (12) @(posedge clk_i);
    if (err_cnt == 0 && pending == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
